/* hw/rtl/bee_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the button map for the button edge event encoder.
// No dependencies; every other file imports this package.
package bee_pkg;

  // Port widths and the used-bit layout
  localparam int unsigned PORT_W       = 16;
  localparam logic [15:0] USED_MASK_A  = 16'hFF03;
  localparam int unsigned NUM_EXP1_BTN = 10;
  localparam int unsigned NUM_BTN      = 26;
  localparam int unsigned POS_W        = $clog2(NUM_BTN);
  localparam int unsigned Q_DEPTH      = 2;

  // Button group codes
  localparam logic [2:0] GRP_SNAPSHOT = 3'd0;
  localparam logic [2:0] GRP_MODE     = 3'd1;
  localparam logic [2:0] GRP_PLAY     = 3'd2;
  localparam logic [2:0] GRP_STOP     = 3'd3;
  localparam logic [2:0] GRP_RECORD   = 3'd4;
  localparam logic [2:0] GRP_TAP      = 3'd5;
  localparam logic [2:0] GRP_SWITCH   = 3'd6;
  localparam logic [2:0] GRP_FUNCTION = 3'd7;

  typedef struct packed {
    logic [PORT_W-1:0] port_a;
    logic [PORT_W-1:0] port_b;
  } in_item_t;

  typedef struct packed {
    logic       word_changed;
    logic       event_valid;
    logic [2:0] event_group;
    logic [2:0] event_index;
    logic       pressed;
    logic       last_of_run;
  } out_item_t;

  // One scan job: changed used bits and new levels in event order, plus word change
  typedef struct packed {
    logic [NUM_BTN-1:0] changed;
    logic [NUM_BTN-1:0] level;
    logic               word_changed;
  } job_t;

  typedef struct packed {
    logic [2:0] group;
    logic [2:0] index;
  } btn_id_t;

  // Pack the used bits in event order: A0, A1, A8..A15, then B0..B15
  function automatic logic [NUM_BTN-1:0] bee_compact(input logic [PORT_W-1:0] a,
                                                     input logic [PORT_W-1:0] b);
    logic [PORT_W-1:0] au;
    au = a & USED_MASK_A;
    return {b, au[15:8], au[1:0]};
  endfunction

  // Group and index of each event position
  function automatic btn_id_t bee_map(input logic [POS_W-1:0] pos);
    btn_id_t id;
    unique case (pos)
      5'd0:    id = '{GRP_SNAPSHOT, 3'd0};
      5'd1:    id = '{GRP_SNAPSHOT, 3'd1};
      5'd2:    id = '{GRP_TAP,      3'd0};
      5'd3:    id = '{GRP_RECORD,   3'd0};
      5'd4:    id = '{GRP_STOP,     3'd0};
      5'd5:    id = '{GRP_PLAY,     3'd0};
      5'd6:    id = '{GRP_MODE,     3'd3};
      5'd7:    id = '{GRP_MODE,     3'd2};
      5'd8:    id = '{GRP_MODE,     3'd1};
      5'd9:    id = '{GRP_MODE,     3'd0};
      5'd10:   id = '{GRP_FUNCTION, 3'd6};
      5'd11:   id = '{GRP_FUNCTION, 3'd7};
      5'd12:   id = '{GRP_FUNCTION, 3'd4};
      5'd13:   id = '{GRP_FUNCTION, 3'd5};
      5'd14:   id = '{GRP_FUNCTION, 3'd2};
      5'd15:   id = '{GRP_FUNCTION, 3'd3};
      5'd16:   id = '{GRP_FUNCTION, 3'd0};
      5'd17:   id = '{GRP_FUNCTION, 3'd1};
      5'd18:   id = '{GRP_SWITCH,   3'd7};
      5'd19:   id = '{GRP_SWITCH,   3'd5};
      5'd20:   id = '{GRP_SWITCH,   3'd3};
      5'd21:   id = '{GRP_SWITCH,   3'd1};
      5'd22:   id = '{GRP_SWITCH,   3'd6};
      5'd23:   id = '{GRP_SWITCH,   3'd4};
      5'd24:   id = '{GRP_SWITCH,   3'd2};
      5'd25:   id = '{GRP_SWITCH,   3'd0};
      default: id = '{GRP_SNAPSHOT, 3'd0};
    endcase
    return id;
  endfunction

endpackage

/* hw/rtl/bee_front.sv */
`timescale 1ns / 1ps
// Front end: accepts port words, compares against the stored pair, builds a scan job.
// Depends on bee_pkg.
module bee_front import bee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     in_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [PORT_W-1:0] prev_a_r, prev_a_nxt;
  logic [PORT_W-1:0] prev_b_r, prev_b_nxt;
  logic [PORT_W-1:0] diff_a, diff_b;
  logic              accept;

  // Refuse items while reset is held
  assign in_full = q_full || !rst_n;
  assign accept  = in_push && !in_full;
  assign q_push  = accept;

  // Classify: changed used bits, new levels, whole-word change
  assign diff_a = in_data.port_a ^ prev_a_r;
  assign diff_b = in_data.port_b ^ prev_b_r;
  assign q_job.changed      = bee_compact(diff_a, diff_b);
  assign q_job.level        = bee_compact(in_data.port_a, in_data.port_b);
  assign q_job.word_changed = (diff_a != '0) || (diff_b != '0);

  // Replace the stored words on every accepted item
  always_comb begin
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;
    if (accept) begin
      prev_a_nxt = in_data.port_a;
      prev_b_nxt = in_data.port_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= '0;
      prev_b_r <= '0;
    end else begin
      prev_a_r <= prev_a_nxt;
      prev_b_r <= prev_b_nxt;
    end
  end

endmodule

/* hw/rtl/bee_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the event scanner.
// Depends on bee_pkg.
module bee_queue import bee_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  job_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hw/rtl/bee_back.sv */
`timescale 1ns / 1ps
// Back end: scans a job bit per cycle unless stalled, emitting events to the output.
// Depends on bee_pkg.
module bee_back import bee_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic               busy_r, busy_nxt;
  logic [NUM_BTN-1:0] mask_r, mask_nxt;
  logic [NUM_BTN-1:0] level_r, level_nxt;
  logic               wc_r, wc_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;
  logic [NUM_BTN-1:0] pos_bit;
  logic [NUM_BTN-1:0] mask_left;
  btn_id_t            id;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = !busy_r && !q_empty;
  assign pos_bit   = NUM_BTN'(1) << pos_r;
  assign mask_left = mask_r & ~pos_bit;
  assign id        = bee_map(pos_r);

  // Load a job, then walk its positions; emit when the output register can take an item
  always_comb begin
    busy_nxt      = busy_r;
    mask_nxt      = mask_r;
    level_nxt     = level_r;
    wc_nxt        = wc_r;
    pos_nxt       = pos_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (!busy_r) begin
      if (!q_empty) begin
        busy_nxt  = 1'b1;
        mask_nxt  = q_job.changed;
        level_nxt = q_job.level;
        wc_nxt    = q_job.word_changed;
        pos_nxt   = '0;
      end
    end else if (mask_r == '0) begin
      // No used bit changed: one plain status item
      if (slot_free) begin
        out_nxt       = '{word_changed: wc_r, event_valid: 1'b0, event_group: '0,
                          event_index: '0, pressed: 1'b0, last_of_run: 1'b1};
        out_valid_nxt = 1'b1;
        busy_nxt      = 1'b0;
      end
    end else if (mask_r[pos_r]) begin
      if (slot_free) begin
        out_nxt       = '{word_changed: 1'b1, event_valid: 1'b1, event_group: id.group,
                          event_index: id.index, pressed: level_r[pos_r],
                          last_of_run: (mask_left == '0)};
        out_valid_nxt = 1'b1;
        mask_nxt      = mask_left;
        pos_nxt       = pos_r + POS_W'(1);
        busy_nxt      = (mask_left != '0);
      end
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold job and output payload
  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    level_r <= level_nxt;
    wc_r    <= wc_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
  end

endmodule

/* hw/rtl/button_edge_event_encoder.sv */
`timescale 1ns / 1ps
// Top level of the button edge event encoder: front end, job queue, event scanner.
// Depends on bee_pkg, bee_front, bee_queue, bee_back.
//
//   channel | ports                        | direction | moves
//   in      | in_push, in_full, in_data    | input     | one item of two port words
//   out     | out_empty, out_pop, out_data | output    | one event or status item
//
// The front end takes an item when the two-entry job queue has room.
// The scanner loads a job, then walks one bit position per cycle up to the last changed
// bit, unless a stalled output holds it; an item with no change yields one status item.
// A stalled output holds the scanner; the queue lets two more items enter meanwhile.
// Synchronous active-low reset clears the stored words, queue and output register.
module button_edge_event_encoder import bee_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wr_job, q_rd_job;

  bee_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .in_full (in_full),
    .q_push  (q_push),
    .q_job   (q_wr_job)
  );

  bee_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_wr_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (q_rd_job)
  );

  bee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_rd_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/bee_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the button edge event encoder, bound to the top level.
// Depends on bee_pkg and button_edge_event_encoder.
module bee_checker import bee_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input in_item_t  in_data,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // Accepted input item carries known port words
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> !$isunknown(in_data))
    else $error("accepted item has unknown bits");

  // Stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled output item changed");

  // Events always report a word change
  a_event_wc: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.event_valid) |-> out_data.word_changed)
    else $error("event without word change");

  // Status items are alone in their run and carry no button
  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.event_valid) |->
      (out_data.last_of_run && out_data.event_group == GRP_SNAPSHOT &&
       out_data.event_index == 3'd0 && !out_data.pressed))
    else $error("malformed status item");

endmodule

bind button_edge_event_encoder bee_checker u_bee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_data   (in_data),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

/* bench/tb_button_edge_event_encoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for button_edge_event_encoder: directed scans, random scans, stall.
// Depends on bee_pkg and the encoder RTL; predicts events from its own copy of the port words.
module tb_button_edge_event_encoder;
  import bee_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_REPORTS = 40;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;

  // Events still owed by the encoder, oldest first
  out_item_t   expected_events[$];
  logic [15:0] scan_prev_a;
  logic [15:0] scan_prev_b;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  logic        push_gaps_on;
  logic        pop_gaps_on;

  button_edge_event_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Group and index of each used bit of port A
  function automatic logic [5:0] a_button(int pos);
    case (pos)
      0:       return {GRP_SNAPSHOT, 3'd0};
      1:       return {GRP_SNAPSHOT, 3'd1};
      8:       return {GRP_TAP,      3'd0};
      9:       return {GRP_RECORD,   3'd0};
      10:      return {GRP_STOP,     3'd0};
      11:      return {GRP_PLAY,     3'd0};
      12:      return {GRP_MODE,     3'd3};
      13:      return {GRP_MODE,     3'd2};
      14:      return {GRP_MODE,     3'd1};
      15:      return {GRP_MODE,     3'd0};
      default: return 6'd0;
    endcase
  endfunction

  // Group and index of each bit of port B
  function automatic logic [5:0] b_button(int pos);
    case (pos)
      0:       return {GRP_FUNCTION, 3'd6};
      1:       return {GRP_FUNCTION, 3'd7};
      2:       return {GRP_FUNCTION, 3'd4};
      3:       return {GRP_FUNCTION, 3'd5};
      4:       return {GRP_FUNCTION, 3'd2};
      5:       return {GRP_FUNCTION, 3'd3};
      6:       return {GRP_FUNCTION, 3'd0};
      7:       return {GRP_FUNCTION, 3'd1};
      8:       return {GRP_SWITCH,   3'd7};
      9:       return {GRP_SWITCH,   3'd5};
      10:      return {GRP_SWITCH,   3'd3};
      11:      return {GRP_SWITCH,   3'd1};
      12:      return {GRP_SWITCH,   3'd6};
      13:      return {GRP_SWITCH,   3'd4};
      14:      return {GRP_SWITCH,   3'd2};
      default: return {GRP_SWITCH,   3'd0};
    endcase
  endfunction

  // Queue the events one accepted scan causes and advance the stored words
  function automatic void predict_events(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] diff_a;
    logic [15:0] diff_b;
    logic [5:0]  id;
    out_item_t   ev;
    int          n;
    diff_a = (a ^ scan_prev_a) & USED_MASK_A;
    diff_b = b ^ scan_prev_b;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (i < 16 ? diff_a[i] : diff_b[i-16]) begin
        id = (i < 16) ? a_button(i) : b_button(i - 16);
        ev.word_changed = 1'b1;
        ev.event_valid  = 1'b1;
        ev.event_group  = id[5:3];
        ev.event_index  = id[2:0];
        ev.pressed      = (i < 16) ? a[i] : b[i-16];
        ev.last_of_run  = 1'b0;
        expected_events.push_back(ev);
        n++;
      end
    end
    if (n == 0) begin
      // no used bit moved: one status item
      ev = '0;
      ev.word_changed = (a != scan_prev_a) || (b != scan_prev_b);
      ev.last_of_run  = 1'b1;
      expected_events.push_back(ev);
    end else begin
      expected_events[expected_events.size()-1].last_of_run = 1'b1;
    end
    scan_prev_a = a;
    scan_prev_b = b;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare one popped item with the oldest expected event
  task automatic check_event(input out_item_t got);
    out_item_t want;
    if (expected_events.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
    end else begin
      want = expected_events.pop_front();
      check_field("word_changed", want.word_changed, got.word_changed);
      check_field("event_valid", want.event_valid, got.event_valid);
      check_field("event_group", want.event_group, got.event_group);
      check_field("event_index", want.event_index, got.event_index);
      check_field("pressed", want.pressed, got.pressed);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
    end
  endtask

  // Pop side: check accepted items, then pick the next pop level
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        check_event(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= !(pop_gaps_on && ($urandom_range(0, 99) < 31));
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one scan and hold it until the encoder takes it
  task automatic send_scan(input logic [15:0] a, input logic [15:0] b);
    int idle;
    idle = 0;
    if (push_gaps_on)
      while ($urandom_range(0, 99) < 31) idle++;
    if (idle > 0) begin
      in_push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_data.port_a <= a;
    in_data.port_b <= b;
    do @(posedge clk); while (in_full);
    predict_events(a, b);
  endtask

  // Extremes, no-change status, unused bits, snapshot release, both words moving
  task automatic test_directed();
    send_scan(16'h0000, 16'h0000);
    send_scan(16'hFFFF, 16'hFFFF);
    send_scan(16'hFFFF, 16'hFFFF);
    send_scan(16'h0000, 16'h0000);
    send_scan(16'h00FC, 16'h0000);
    send_scan(16'h0002, 16'h0000);
    send_scan(16'h0000, 16'h0000);
    send_scan(16'h0001, 16'h0001);
    send_scan(16'h8000, 16'h8000);
    send_scan(16'h5A5A, 16'hA5A5);
    send_scan(16'hA5A5, 16'h5A5A);
    send_scan(16'hA5A5, 16'h5A5A);
    send_scan(16'h0300, 16'h0000);
    send_scan(16'h0300, 16'hFFFF);
    send_scan(16'hFC03, 16'hFFFF);
    send_scan(16'h0000, 16'h0000);
  endtask

  // Mostly a few buttons moving per scan, plus status-only and noise scans
  task automatic test_random();
    logic [15:0] a;
    logic [15:0] b;
    int          r;
    int          pos;
    for (int k = 0; k < 160; k++) begin
      // quiet stretch with no idling on either side
      push_gaps_on = !(k >= 70 && k < 110);
      pop_gaps_on  = !(k >= 70 && k < 110);
      a = scan_prev_a;
      b = scan_prev_b;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(1, 3)) begin
          pos = $urandom_range(0, 25);
          if (pos < 2)                       a[pos] = ~a[pos];
          else if (pos < int'(NUM_EXP1_BTN)) a[pos+6] = ~a[pos+6];
          else                               b[pos-10] = ~b[pos-10];
        end
      end else if (r < 65) begin
        // hold both words
      end else if (r < 75) begin
        a = a ^ (16'($urandom_range(1, 63)) << 2);
      end else if (r < 85) begin
        a = a ^ (16'($urandom) & USED_MASK_A);
        b = b ^ 16'($urandom);
      end else begin
        a = 16'($urandom);
        b = 16'($urandom);
      end
      send_scan(a, b);
    end
    push_gaps_on = 1'b1;
    pop_gaps_on  = 1'b1;
  endtask

  // Hold the pop side off while full scans keep coming, so in_full must rise
  task automatic test_stall();
    push_gaps_on = 1'b0;
    hold_left = 400;
    for (int k = 0; k < 6; k++)
      send_scan(k[0] ? 16'h0000 : 16'hFFFF, k[0] ? 16'h0000 : 16'hFFFF);
    push_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    out_pop      = 1'b0;
    hold_left    = 0;
    push_gaps_on = 1'b1;
    pop_gaps_on  = 1'b1;
    error_count  = 0;
    scan_prev_a  = '0;
    scan_prev_b  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_stall();
    test_random();
    in_push <= 1'b0;

    // drain, then let the scanner settle
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
